// ===== rtl/core/settable_clock_mux_display_top_assert.svh =====
// Assertion macros used by the clock display checker.
`ifndef SETTABLE_CLOCK_MUX_DISPLAY_TOP_ASSERT_SVH
`define SETTABLE_CLOCK_MUX_DISPLAY_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SCMD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clock display check failed");

// Next-cycle implication, checked on every clock edge out of reset.
`define SCMD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clock display check failed");

`endif

// ===== rtl/core/scmd_pkg.sv =====
// Package: constants, key codes and decode functions for the clock display.
package scmd_pkg;

  localparam logic [15:0] DIVIDE_RESET = 16'd960;
  localparam logic [5:0]  SEC_RESET    = 6'd59;
  localparam logic [5:0]  MIN_RESET    = 6'd59;
  localparam logic [4:0]  HOUR_RESET   = 5'd23;
  localparam logic [5:0]  SEC_MAX      = 6'd59;
  localparam logic [5:0]  MIN_MAX      = 6'd59;
  localparam logic [4:0]  HOUR_MAX     = 5'd23;
  localparam logic [2:0]  LAST_SLOT    = 3'd5;
  localparam logic [7:0]  DP_BIT       = 8'h80;

  // Field codes
  localparam logic [1:0] FIELD_SEC  = 2'd0;
  localparam logic [1:0] FIELD_MIN  = 2'd1;
  localparam logic [1:0] FIELD_HOUR = 2'd2;

  // Keyboard column codes
  localparam logic [2:0] COL_EDIT  = 3'd0;
  localparam logic [2:0] COL_CLEAR = 3'd1;
  localparam logic [2:0] COL_LEFT  = 3'd2;
  localparam logic [2:0] COL_INC   = 3'd3;
  localparam logic [2:0] COL_DEC   = 3'd4;
  localparam logic [2:0] COL_RIGHT = 3'd5;

  // Wrapping advance of a display slot or scan column
  function automatic logic [2:0] next_slot(input logic [2:0] v);
    next_slot = (v >= LAST_SLOT) ? 3'd0 : v + 3'd1;
  endfunction

  // One decimal digit of a value below 64; tens via compares, ones by subtraction
  function automatic logic [3:0] digit_of(input logic [5:0] v, input logic tens);
    logic [2:0] t;
    logic [5:0] o;
    t = (v >= 6'd60) ? 3'd6 : (v >= 6'd50) ? 3'd5 : (v >= 6'd40) ? 3'd4 :
        (v >= 6'd30) ? 3'd3 : (v >= 6'd20) ? 3'd2 : (v >= 6'd10) ? 3'd1 : 3'd0;
    o = v - 6'({t, 3'b000} + {2'b00, t, 1'b0});
    digit_of = tens ? {1'b0, t} : o[3:0];
  endfunction

  // Seven-segment decode, digits above nine show as nine
  function automatic logic [7:0] seg_decode(input logic [3:0] d);
    case (d)
      4'd0:    seg_decode = 8'b0011_1111;
      4'd1:    seg_decode = 8'b0000_0110;
      4'd2:    seg_decode = 8'b0101_1011;
      4'd3:    seg_decode = 8'b0100_1111;
      4'd4:    seg_decode = 8'b0110_0110;
      4'd5:    seg_decode = 8'b0110_1101;
      4'd6:    seg_decode = 8'b0111_1101;
      4'd7:    seg_decode = 8'b0000_0111;
      4'd8:    seg_decode = 8'b0111_1111;
      default: seg_decode = 8'b0110_1111;
    endcase
  endfunction

endpackage

// ===== rtl/core/settable_clock_mux_display_top.sv =====
// Top level: settable clock with multiplexed seven-segment display and scanned keys.
// One input transaction is one tick carrying the sensed key return line; each tick yields
// exactly one registered result transaction: the digit driven with its segment pattern
// (decimal point marks the field being edited) and the time, edit mode and field after the
// tick. All state updates in the cycle the tick is taken, so a tick can be taken every
// cycle; the single output register is the only thing that holds input off, and only while
// a result waits under out_stall. tick_divide sets how many ticks make one second and is
// written through the cfg port, which is always ready.
module settable_clock_mux_display_top (
  input  logic        clk,
  input  logic        rst_n,
  // tick input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_key_sensed,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_digit_select,
  output logic [7:0]  out_segments,
  output logic [4:0]  out_hours_now,
  output logic [5:0]  out_minutes_now,
  output logic [5:0]  out_seconds_now,
  output logic        out_edit_active,
  output logic [1:0]  out_field_chosen,
  // divider write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_tick_divide
);

  logic [15:0] tick_divide_r;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [5:0]  seconds_r, seconds_nxt;
  logic [5:0]  minutes_r, minutes_nxt;
  logic [4:0]  hours_r, hours_nxt;
  logic        editing_r, editing_nxt;
  logic [1:0]  field_index_r, field_index_nxt;
  logic [2:0]  digit_index_r;
  logic [2:0]  scan_column_r;
  logic [2:0]  latched_column_r, latched_column_nxt;
  logic        press_held_r, press_held_nxt;

  logic        out_valid_r;
  logic [2:0]  digit_select_r;
  logic [7:0]  segments_r, segments_nxt;

  logic        in_accept;
  logic [2:0]  shown;
  logic [1:0]  shown_field;
  logic [5:0]  shown_val;
  logic        new_press, act;
  logic        do_clear, do_inc, do_dec;
  logic        inc_s, inc_m, inc_h, dec_s, dec_m, dec_h;
  logic [15:0] count_inc;
  logic        count_hit, tick_adv;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Display: decode the current digit, decimal point on the edited field
  always_comb begin
    shown       = (digit_index_r > scmd_pkg::LAST_SLOT) ? 3'd0 : digit_index_r;
    shown_field = shown[2:1];
    case (shown_field)
      scmd_pkg::FIELD_SEC: shown_val = seconds_r;
      scmd_pkg::FIELD_MIN: shown_val = minutes_r;
      default:             shown_val = {1'b0, hours_r};
    endcase
    segments_nxt = scmd_pkg::seg_decode(scmd_pkg::digit_of(shown_val, shown[0]));
    if (editing_r && field_index_r == shown_field) begin
      segments_nxt = segments_nxt | scmd_pkg::DP_BIT;
    end
  end

  // Keyboard: edit toggle, press latch and edit actions
  always_comb begin
    new_press          = in_key_sensed && !press_held_r;
    editing_nxt        = editing_r ^ (new_press && scan_column_r == scmd_pkg::COL_EDIT);
    act                = new_press && editing_nxt;
    do_clear           = act && scan_column_r == scmd_pkg::COL_CLEAR;
    do_inc             = act && scan_column_r == scmd_pkg::COL_INC;
    do_dec             = act && scan_column_r == scmd_pkg::COL_DEC;
    latched_column_nxt = in_key_sensed ? scan_column_r : latched_column_r;
    press_held_nxt     = press_held_r;
    field_index_nxt    = field_index_r;
    if (in_key_sensed) begin
      if (new_press && (scan_column_r == scmd_pkg::COL_EDIT ||
          (editing_nxt && scan_column_r <= scmd_pkg::COL_RIGHT))) begin
        press_held_nxt = 1'b1;
      end
    end else if (latched_column_r == scan_column_r) begin
      press_held_nxt = 1'b0;
    end
    if (act && scan_column_r == scmd_pkg::COL_LEFT && field_index_r != 2'd0) begin
      field_index_nxt = field_index_r - 2'd1;
    end
    if (act && scan_column_r == scmd_pkg::COL_RIGHT && field_index_r < scmd_pkg::FIELD_HOUR) begin
      field_index_nxt = field_index_r + 2'd1;
    end
  end

  // Count: tick divider, one second per match while not editing
  always_comb begin
    count_inc      = tick_count_r + 16'd1;
    count_hit      = count_inc == tick_divide_r;
    tick_count_nxt = count_hit ? 16'd0 : count_inc;
    tick_adv       = count_hit && !editing_nxt;
  end

  // Time update with carry and borrow; key edits and count advance never coincide
  always_comb begin
    inc_s = (do_inc && field_index_r == scmd_pkg::FIELD_SEC) || tick_adv;
    inc_m = (do_inc && field_index_r == scmd_pkg::FIELD_MIN) ||
            (inc_s && seconds_r >= scmd_pkg::SEC_MAX);
    inc_h = (do_inc && field_index_r == scmd_pkg::FIELD_HOUR) ||
            (inc_m && minutes_r >= scmd_pkg::MIN_MAX);
    dec_s = do_dec && field_index_r == scmd_pkg::FIELD_SEC;
    dec_m = (do_dec && field_index_r == scmd_pkg::FIELD_MIN) ||
            (dec_s && (seconds_r == 6'd0 || seconds_r > scmd_pkg::SEC_MAX));
    dec_h = (do_dec && field_index_r == scmd_pkg::FIELD_HOUR) ||
            (dec_m && (minutes_r == 6'd0 || minutes_r > scmd_pkg::MIN_MAX));

    if (do_clear) begin
      seconds_nxt = 6'd0;
    end else if (inc_s) begin
      seconds_nxt = (seconds_r >= scmd_pkg::SEC_MAX) ? 6'd0 : seconds_r + 6'd1;
    end else if (dec_s) begin
      seconds_nxt = (seconds_r == 6'd0 || seconds_r > scmd_pkg::SEC_MAX) ?
                    scmd_pkg::SEC_MAX : seconds_r - 6'd1;
    end else begin
      seconds_nxt = seconds_r;
    end

    if (do_clear) begin
      minutes_nxt = 6'd0;
    end else if (inc_m) begin
      minutes_nxt = (minutes_r >= scmd_pkg::MIN_MAX) ? 6'd0 : minutes_r + 6'd1;
    end else if (dec_m) begin
      minutes_nxt = (minutes_r == 6'd0 || minutes_r > scmd_pkg::MIN_MAX) ?
                    scmd_pkg::MIN_MAX : minutes_r - 6'd1;
    end else begin
      minutes_nxt = minutes_r;
    end

    if (do_clear) begin
      hours_nxt = 5'd0;
    end else if (inc_h) begin
      hours_nxt = (hours_r >= scmd_pkg::HOUR_MAX) ? 5'd0 : hours_r + 5'd1;
    end else if (dec_h) begin
      hours_nxt = (hours_r == 5'd0 || hours_r > scmd_pkg::HOUR_MAX) ?
                  scmd_pkg::HOUR_MAX : hours_r - 5'd1;
    end else begin
      hours_nxt = hours_r;
    end
  end

  // Divider register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divide_r <= scmd_pkg::DIVIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tick_divide_r <= cfg_tick_divide;
    end
  end

  // Clock state, advanced once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r     <= 16'd0;
      seconds_r        <= scmd_pkg::SEC_RESET;
      minutes_r        <= scmd_pkg::MIN_RESET;
      hours_r          <= scmd_pkg::HOUR_RESET;
      editing_r        <= 1'b0;
      field_index_r    <= scmd_pkg::FIELD_SEC;
      digit_index_r    <= 3'd0;
      scan_column_r    <= scmd_pkg::COL_EDIT;
      latched_column_r <= scmd_pkg::COL_EDIT;
      press_held_r     <= 1'b0;
    end else if (in_accept) begin
      tick_count_r     <= tick_count_nxt;
      seconds_r        <= seconds_nxt;
      minutes_r        <= minutes_nxt;
      hours_r          <= hours_nxt;
      editing_r        <= editing_nxt;
      field_index_r    <= field_index_nxt;
      digit_index_r    <= scmd_pkg::next_slot(digit_index_r);
      scan_column_r    <= scmd_pkg::next_slot(scan_column_r);
      latched_column_r <= latched_column_nxt;
      press_held_r     <= press_held_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      digit_select_r <= shown;
      segments_r     <= segments_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = digit_select_r;
  assign out_segments     = segments_r;
  // Time and mode fields are the state after the last accepted tick
  assign out_hours_now    = hours_r;
  assign out_minutes_now  = minutes_r;
  assign out_seconds_now  = seconds_r;
  assign out_edit_active  = editing_r;
  assign out_field_chosen = field_index_r;

endmodule

// ===== rtl/core/scmd_checker.sv =====
// Port-level checker for the clock display, bound to the top level.
`include "settable_clock_mux_display_top_assert.svh"

module scmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_key_sensed,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_digit_select,
  input logic [7:0]  out_segments,
  input logic [4:0]  out_hours_now,
  input logic [5:0]  out_minutes_now,
  input logic [5:0]  out_seconds_now,
  input logic        out_edit_active,
  input logic [1:0]  out_field_chosen,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_tick_divide
);

  // A stalled result transaction holds
  `SCMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_segments) && $stable(out_digit_select))

  // Every accepted tick produces a result on the next cycle
  `SCMD_ASSERT_NEXT(a_tick_result, in_valid && !in_stall, out_valid)

  // An empty result register never holds off input
  `SCMD_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall)

  // Shown values stay in range
  `SCMD_ASSERT_NOW(a_ranges, out_valid, out_digit_select <= scmd_pkg::LAST_SLOT && out_hours_now <= scmd_pkg::HOUR_MAX && out_minutes_now <= scmd_pkg::MIN_MAX && out_seconds_now <= scmd_pkg::SEC_MAX && out_field_chosen <= scmd_pkg::FIELD_HOUR)

endmodule

bind settable_clock_mux_display_top scmd_checker u_scmd_checker (.*);
